// File: src/shadow_frustum_ortho_fit_top_assert.svh
`ifndef SHADOW_FRUSTUM_ORTHO_FIT_TOP_ASSERT_SVH
`define SHADOW_FRUSTUM_ORTHO_FIT_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define SFOF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define SFOF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/sfof_pkg.sv
`timescale 1ns / 1ps
package sfof_pkg;

	// Register indexes of the configuration port
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_POS_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_POS_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_POS_Z   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_ROT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TAN_HALF    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_ASPECT = 3'd6;
	localparam int CFG_DATA_W = 64;

	// Reset values of the registers
	localparam logic [63:0] ROT_RST    = 64'd16384;
	localparam logic [30:0] NEAR_RST   = 31'd6554;
	localparam logic [30:0] TAN_RST    = 31'd65536;
	localparam logic [30:0] ASPECT_RST = 31'd116508;

	// Saturation limits
	localparam logic signed [31:0] S32_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN   = -32'sh8000_0000;
	localparam logic signed [63:0] S32_MAX_W = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN_W = -64'sd2147483648;
	localparam int U31_W = 31;
	localparam logic [U31_W-1:0] U31_MAX = '1;

	typedef struct packed {
		logic signed [15:0] light_qw;
		logic signed [15:0] light_qx;
		logic signed [15:0] light_qy;
		logic signed [15:0] light_qz;
		logic [30:0]        frustum_range;
		logic signed [31:0] back_extension;
	} item_t;

	typedef struct packed {
		logic signed [31:0] ortho_pos_x;
		logic signed [31:0] ortho_pos_y;
		logic signed [31:0] ortho_pos_z;
		logic signed [31:0] depth_range;
		logic [30:0]        view_width;
		logic [30:0]        ortho_aspect;
		logic               aspect_saturated;
	} result_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [63:0]        rot;
		logic [30:0]        near;
		logic [30:0]        tan_half;
		logic [30:0]        aspect;
	} cfg_t;

	// 3x3 matrix, entry [row*3+col]
	typedef logic [8:0][31:0] mat_t;

	// Work handed from the front end to the back end
	typedef struct packed {
		mat_t               lm;
		mat_t               cm;
		logic [1:0][30:0]   slice_d;
		logic [1:0][30:0]   hh;
		logic [1:0][30:0]   hw;
		logic signed [31:0] back;
	} mid_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX_W)
			r = S32_MAX;
		else if (v < S32_MIN_W)
			r = S32_MIN;
		else
			r = v[31:0];
		return r;
	endfunction

	// Round half up, then drop s fraction bits
	function automatic logic signed [63:0] rsh_round(input logic signed [63:0] v, input int s);
		logic signed [63:0] half;
		half = 64'sd1 <<< (s - 1);
		return (v + half) >>> s;
	endfunction

	// Unsigned product rescale with round half up and clamp to 31 bits
	function automatic logic [30:0] scale_clamp(input logic [61:0] p, input int f);
		logic [62:0] t;
		t = ({1'b0, p} + (63'd1 << (f - 1))) >> f;
		return (t > 63'(U31_MAX)) ? U31_MAX : t[30:0];
	endfunction

endpackage

// File: src/sfof_fifo.sv
`timescale 1ns / 1ps
module sfof_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic                  pop,
	input  logic [W-1:0]          din,
	output logic [W-1:0]          dout,
	output sfof_pkg::fifo_stat_t  stat
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign do_push = push && (cnt_q != CW'(DEPTH));
	assign do_pop  = pop && (cnt_q != '0);

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= din;
	end

	assign dout       = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule

// File: src/sfof_front.sv
`timescale 1ns / 1ps
module sfof_front #(
	parameter int FRAC_BITS      = 16,
	parameter int QUAT_FRAC_BITS = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  sfof_pkg::item_t  item,
	input  sfof_pkg::cfg_t   cfg,
	output logic             out_valid,
	output sfof_pkg::mid_t   mid
);
	// Width of the doubled-precision rotation sums
	localparam int PW = (2 * QUAT_FRAC_BITS + 3 > 36) ? 2 * QUAT_FRAC_BITS + 3 : 36;

	// Product order within a mat_t slot
	localparam int P_XX = 0, P_YY = 1, P_ZZ = 2, P_XY = 3, P_XZ = 4;
	localparam int P_YZ = 5, P_WX = 6, P_WY = 7, P_WZ = 8;

	logic signed [15:0] qw [2], qx [2], qy [2], qz [2];
	sfof_pkg::mat_t     prod [2];
	logic [61:0]        tn, tr;

	logic               v_s1, v_s2, v_s3;
	sfof_pkg::mat_t     prod_s1 [2];
	logic [61:0]        tn_s1, tr_s1;
	logic [30:0]        range_s1, range_s2, range_s3;
	logic signed [31:0] back_s1, back_s2, back_s3;
	sfof_pkg::mat_t     lm_s2, cm_s2, lm_s3, cm_s3;
	logic [30:0]        hh_s2 [2], hh_s3 [2];
	logic [61:0]        hwp_s3 [2];

	function automatic logic [31:0] ent(input logic signed [PW-1:0] v);
		return sfof_pkg::sat32(sfof_pkg::rsh_round(64'(v), QUAT_FRAC_BITS));
	endfunction

	// Rotation matrix from the nine quaternion products
	function automatic sfof_pkg::mat_t build_mat(input sfof_pkg::mat_t p);
		logic signed [PW-1:0] one, xx, yy, zz, xy, xz, yz, wx, wy, wz;
		sfof_pkg::mat_t m;
		one = '0;
		one[2 * QUAT_FRAC_BITS] = 1'b1;
		xx = PW'($signed(p[P_XX]));
		yy = PW'($signed(p[P_YY]));
		zz = PW'($signed(p[P_ZZ]));
		xy = PW'($signed(p[P_XY]));
		xz = PW'($signed(p[P_XZ]));
		yz = PW'($signed(p[P_YZ]));
		wx = PW'($signed(p[P_WX]));
		wy = PW'($signed(p[P_WY]));
		wz = PW'($signed(p[P_WZ]));
		m[0] = ent(one - ((yy + zz) <<< 1));
		m[1] = ent((xy - wz) <<< 1);
		m[2] = ent((xz + wy) <<< 1);
		m[3] = ent((xy + wz) <<< 1);
		m[4] = ent(one - ((xx + zz) <<< 1));
		m[5] = ent((yz - wx) <<< 1);
		m[6] = ent((xz - wy) <<< 1);
		m[7] = ent((yz + wx) <<< 1);
		m[8] = ent(one - ((xx + yy) <<< 1));
		return m;
	endfunction

	// Light quaternion from the item, camera quaternion from the registers
	always_comb begin
		qw[0] = item.light_qw;
		qx[0] = item.light_qx;
		qy[0] = item.light_qy;
		qz[0] = item.light_qz;
		qw[1] = cfg.rot[15:0];
		qx[1] = cfg.rot[31:16];
		qy[1] = cfg.rot[47:32];
		qz[1] = cfg.rot[63:48];
		for (int g = 0; g < 2; g++) begin
			prod[g][P_XX] = qx[g] * qx[g];
			prod[g][P_YY] = qy[g] * qy[g];
			prod[g][P_ZZ] = qz[g] * qz[g];
			prod[g][P_XY] = qx[g] * qy[g];
			prod[g][P_XZ] = qx[g] * qz[g];
			prod[g][P_YZ] = qy[g] * qz[g];
			prod[g][P_WX] = qw[g] * qx[g];
			prod[g][P_WY] = qw[g] * qy[g];
			prod[g][P_WZ] = qw[g] * qz[g];
		end
		tn = 62'(cfg.tan_half) * 62'(cfg.near);
		tr = 62'(cfg.tan_half) * 62'(item.frustum_range);
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Products, then matrices and heights, then width products
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1[0] <= prod[0];
			prod_s1[1] <= prod[1];
			tn_s1      <= tn;
			tr_s1      <= tr;
			range_s1   <= item.frustum_range;
			back_s1    <= item.back_extension;

			lm_s2    <= build_mat(prod_s1[0]);
			cm_s2    <= build_mat(prod_s1[1]);
			hh_s2[0] <= sfof_pkg::scale_clamp(tn_s1, FRAC_BITS);
			hh_s2[1] <= sfof_pkg::scale_clamp(tr_s1, FRAC_BITS);
			range_s2 <= range_s1;
			back_s2  <= back_s1;

			hwp_s3[0] <= 62'(hh_s2[0]) * 62'(cfg.aspect);
			hwp_s3[1] <= 62'(hh_s2[1]) * 62'(cfg.aspect);
			hh_s3     <= hh_s2;
			lm_s3     <= lm_s2;
			cm_s3     <= cm_s2;
			range_s3  <= range_s2;
			back_s3   <= back_s2;
		end
	end

	// Work item for the queue
	always_comb begin
		mid.lm         = lm_s3;
		mid.cm         = cm_s3;
		mid.slice_d[0] = cfg.near;
		mid.slice_d[1] = range_s3;
		mid.hh[0]      = hh_s3[0];
		mid.hh[1]      = hh_s3[1];
		mid.hw[0]      = sfof_pkg::scale_clamp(hwp_s3[0], FRAC_BITS);
		mid.hw[1]      = sfof_pkg::scale_clamp(hwp_s3[1], FRAC_BITS);
		mid.back       = back_s3;
	end

	assign out_valid = v_s3;

endmodule

// File: src/sfof_div.sv
`timescale 1ns / 1ps
module sfof_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [31:0]         num,
	input  logic [31:0]         den,
	input  sfof_pkg::result_t   info,
	output logic                out_valid,
	output sfof_pkg::result_t   result
);
	// One quotient bit per stage, below the overflow test
	localparam int NSTG = sfof_pkg::U31_W;
	localparam int RW   = 64;

	logic [NSTG:0]     vld_s;
	logic [RW-1:0]     rem_s [NSTG+1];
	logic [31:0]       den_s [NSTG+1];
	logic [NSTG-1:0]   quo_s [NSTG+1];
	logic              sat_s [NSTG+1];
	sfof_pkg::result_t info_s [NSTG+1];

	logic [RW-1:0] dvd, lim;
	logic [RW-1:0] cand [NSTG+1];
	logic          ge [NSTG+1];

	always_comb begin
		dvd = RW'(num) << FRAC_BITS;
		lim = RW'(den) << NSTG;
		cand[0] = '0;
		ge[0]   = 1'b0;
		for (int n = 1; n <= NSTG; n++) begin
			cand[n] = RW'(den_s[n-1]) << (NSTG - n);
			ge[n]   = (rem_s[n-1] >= cand[n]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[NSTG-1:0], in_valid};
	end

	// Restoring division, one step per stage
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= dvd;
			den_s[0]  <= den;
			quo_s[0]  <= '0;
			sat_s[0]  <= (den == '0) || (dvd >= lim);
			info_s[0] <= info;
			for (int n = 1; n <= NSTG; n++) begin
				rem_s[n]  <= ge[n] ? rem_s[n-1] - cand[n] : rem_s[n-1];
				quo_s[n]  <= ge[n] ? quo_s[n-1] | (NSTG'(1) << (NSTG - n)) : quo_s[n-1];
				den_s[n]  <= den_s[n-1];
				sat_s[n]  <= sat_s[n-1];
				info_s[n] <= info_s[n-1];
			end
		end
	end

	always_comb begin
		result                  = info_s[NSTG];
		result.ortho_aspect     = sat_s[NSTG] ? sfof_pkg::U31_MAX : quo_s[NSTG];
		result.aspect_saturated = sat_s[NSTG];
	end

	assign out_valid = vld_s[NSTG];

endmodule

// File: src/sfof_back.sv
`timescale 1ns / 1ps
module sfof_back #(
	parameter int FRAC_BITS      = 16,
	parameter int QUAT_FRAC_BITS = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  sfof_pkg::mid_t      mid,
	input  sfof_pkg::cfg_t      cfg,
	output logic                out_valid,
	output sfof_pkg::result_t   result
);
	localparam int Q = QUAT_FRAC_BITS;

	logic [9:1] v_s;

	// Stage 1: camera-axis terms
	logic signed [63:0] pd_s1 [3][2], pu_s1 [3][2], pr_s1 [3][2];
	sfof_pkg::mat_t     lm_s1, lm_s2, lm_s3, lm_s4, lm_s5, lm_s6, lm_s7;
	logic signed [31:0] back_s1, back_s2, back_s3, back_s4, back_s5, back_s6;
	// Stage 2: world corners
	logic signed [31:0] cn_s2 [8][3];
	// Stage 3: light-space products
	logic signed [63:0] lp_prod_s3 [8][3][3];
	// Stage 4: light-space corners
	logic signed [31:0] lc_s4 [8][3];
	// Stages 5 and 6: min and max tree
	logic signed [31:0] mn_s5 [3][4], mx_s5 [3][4];
	logic signed [31:0] mn_s6 [3], mx_s6 [3];
	// Stage 7: extents and light-space position
	logic signed [31:0] lp_s7 [3];
	logic signed [31:0] depth_s7, depth_s8, depth_s9;
	logic [30:0]        width_s7, width_s8, width_s9;
	logic [31:0]        xe_s7, ze_s7, xe_s8, ze_s8, xe_s9, ze_s9;
	// Stage 8 and 9: back to world space
	logic signed [63:0] fp_s8 [3][3];
	logic signed [31:0] pos_s9 [3];

	logic signed [31:0] cpos [3];
	logic signed [31:0] cn [8][3];
	logic signed [31:0] lc [8][3];
	logic signed [31:0] mn4 [3][4], mx4 [3][4];
	logic signed [31:0] mn1 [3], mx1 [3];
	logic signed [31:0] lp [3], pos [3];
	logic signed [31:0] depth;
	logic [30:0]        width;
	logic signed [63:0] xe, ye, ze;
	sfof_pkg::result_t  info;

	assign cpos[0] = cfg.pos_x;
	assign cpos[1] = cfg.pos_y;
	assign cpos[2] = cfg.pos_z;

	// Corners: position plus depth, up and right terms with per-corner signs
	always_comb begin
		logic signed [63:0] acc, td, tu, tr;
		for (int c = 0; c < 8; c++) begin
			for (int i = 0; i < 3; i++) begin
				td  = sfof_pkg::rsh_round(pd_s1[i][c / 4], Q);
				tu  = sfof_pkg::rsh_round(pu_s1[i][c / 4], Q);
				tr  = sfof_pkg::rsh_round(pr_s1[i][c / 4], Q);
				acc = 64'(cpos[i]) + td;
				acc = ((c % 4) < 2) ? acc + tu : acc - tu;
				acc = ((c % 2) == 1) ? acc + tr : acc - tr;
				cn[c][i] = sfof_pkg::sat32(acc);
			end
		end
	end

	// Light-space corners from the rounded products
	always_comb begin
		logic signed [63:0] acc;
		for (int c = 0; c < 8; c++) begin
			for (int k = 0; k < 3; k++) begin
				acc = '0;
				for (int j = 0; j < 3; j++)
					acc = acc + sfof_pkg::rsh_round(lp_prod_s3[c][k][j], Q);
				lc[c][k] = sfof_pkg::sat32(acc);
			end
		end
	end

	// Min and max tree, pairs first
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 4; i++) begin
				mn4[k][i] = (lc_s4[2*i][k] < lc_s4[2*i+1][k]) ?
					lc_s4[2*i][k] : lc_s4[2*i+1][k];
				mx4[k][i] = (lc_s4[2*i][k] > lc_s4[2*i+1][k]) ?
					lc_s4[2*i][k] : lc_s4[2*i+1][k];
			end
		end
		for (int k = 0; k < 3; k++) begin
			mn1[k] = mn_s5[k][0];
			mx1[k] = mx_s5[k][0];
			for (int i = 1; i < 4; i++) begin
				if (mn_s5[k][i] < mn1[k])
					mn1[k] = mn_s5[k][i];
				if (mx_s5[k][i] > mx1[k])
					mx1[k] = mx_s5[k][i];
			end
		end
	end

	// Extents, centre and pull-back position
	always_comb begin
		xe    = 64'(mx_s6[0]) - 64'(mn_s6[0]);
		ye    = 64'(mx_s6[1]) - 64'(mn_s6[1]);
		ze    = 64'(mx_s6[2]) - 64'(mn_s6[2]);
		lp[0] = sfof_pkg::sat32(sfof_pkg::rsh_round(64'(mn_s6[0]) + 64'(mx_s6[0]), 1));
		lp[1] = sfof_pkg::sat32(64'(mn_s6[1]) - 64'(back_s6));
		lp[2] = sfof_pkg::sat32(sfof_pkg::rsh_round(64'(mn_s6[2]) + 64'(mx_s6[2]), 1));
		depth = sfof_pkg::sat32(64'(back_s6) + ye);
		width = (xe > 64'(sfof_pkg::U31_MAX)) ? sfof_pkg::U31_MAX : xe[30:0];
	end

	// World position of the shadow camera
	always_comb begin
		logic signed [63:0] acc;
		for (int i = 0; i < 3; i++) begin
			acc = '0;
			for (int k = 0; k < 3; k++)
				acc = acc + sfof_pkg::rsh_round(fp_s8[i][k], Q);
			pos[i] = sfof_pkg::sat32(acc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[8:1], in_valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int s = 0; s < 2; s++) begin
					pd_s1[i][s] <= $signed(mid.cm[i*3+1]) * $signed({1'b0, mid.slice_d[s]});
					pu_s1[i][s] <= $signed(mid.cm[i*3+2]) * $signed({1'b0, mid.hh[s]});
					pr_s1[i][s] <= $signed(mid.cm[i*3]) * $signed({1'b0, mid.hw[s]});
				end
			end
			lm_s1   <= mid.lm;
			back_s1 <= mid.back;

			cn_s2   <= cn;
			lm_s2   <= lm_s1;
			back_s2 <= back_s1;

			for (int c = 0; c < 8; c++)
				for (int k = 0; k < 3; k++)
					for (int j = 0; j < 3; j++)
						lp_prod_s3[c][k][j] <= $signed(lm_s2[j*3+k]) * cn_s2[c][j];
			lm_s3   <= lm_s2;
			back_s3 <= back_s2;

			lc_s4   <= lc;
			lm_s4   <= lm_s3;
			back_s4 <= back_s3;

			mn_s5   <= mn4;
			mx_s5   <= mx4;
			lm_s5   <= lm_s4;
			back_s5 <= back_s4;

			mn_s6   <= mn1;
			mx_s6   <= mx1;
			lm_s6   <= lm_s5;
			back_s6 <= back_s5;

			lp_s7    <= lp;
			depth_s7 <= depth;
			width_s7 <= width;
			xe_s7    <= xe[31:0];
			ze_s7    <= ze[31:0];
			lm_s7    <= lm_s6;

			for (int i = 0; i < 3; i++)
				for (int k = 0; k < 3; k++)
					fp_s8[i][k] <= $signed(lm_s7[i*3+k]) * lp_s7[k];
			depth_s8 <= depth_s7;
			width_s8 <= width_s7;
			xe_s8    <= xe_s7;
			ze_s8    <= ze_s7;

			pos_s9   <= pos;
			depth_s9 <= depth_s8;
			width_s9 <= width_s8;
			xe_s9    <= xe_s8;
			ze_s9    <= ze_s8;
		end
	end

	always_comb begin
		info.ortho_pos_x      = pos_s9[0];
		info.ortho_pos_y      = pos_s9[1];
		info.ortho_pos_z      = pos_s9[2];
		info.depth_range      = depth_s9;
		info.view_width       = width_s9;
		info.ortho_aspect     = '0;
		info.aspect_saturated = 1'b0;
	end

	// Aspect quotient, fields ride along with it
	sfof_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s[9]),
		.num       (xe_s9),
		.den       (ze_s9),
		.info      (info),
		.out_valid (out_valid),
		.result    (result)
	);

endmodule

// File: src/shadow_frustum_ortho_fit_top.sv
`timescale 1ns / 1ps
// Orthographic shadow-camera fit: one light quaternion, slice range and pull-back per item,
// one result per item, in order. A new item is taken every cycle while the result queue
// is drained; on its way to the head of the result queue an item passes through
// 3 front stages, the work queue, 9 back stages, then 32 stages of the aspect divider (an
// overflow test, then one quotient bit per stage). The front end stalls only when
// its work queue is full, the back end only when the result queue is full. Camera
// registers must be written while no item is in flight.
module shadow_frustum_ortho_fit_top #(
	parameter int FRAC_BITS      = 16,
	parameter int QUAT_FRAC_BITS = 14,
	parameter int MID_DEPTH      = 4,
	parameter int OUT_DEPTH      = 2
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  sfof_pkg::item_t                      item,
	output logic                                 empty,
	input  logic                                 pop,
	output sfof_pkg::result_t                    result,
	input  logic                                 cfg_we,
	input  logic [sfof_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sfof_pkg::CFG_DATA_W-1:0]      cfg_data
);
	sfof_pkg::cfg_t       cfg_q;
	sfof_pkg::fifo_stat_t mid_stat, out_stat;
	sfof_pkg::mid_t       f_mid, b_mid;
	sfof_pkg::result_t    b_res;
	logic [$bits(sfof_pkg::mid_t)-1:0]    mid_dout;
	logic [$bits(sfof_pkg::result_t)-1:0] out_dout;
	logic                 en_f, en_b, f_valid, b_valid;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_x    <= '0;
			cfg_q.pos_y    <= '0;
			cfg_q.pos_z    <= '0;
			cfg_q.rot      <= sfof_pkg::ROT_RST;
			cfg_q.near     <= sfof_pkg::NEAR_RST;
			cfg_q.tan_half <= sfof_pkg::TAN_RST;
			cfg_q.aspect   <= sfof_pkg::ASPECT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sfof_pkg::REG_CAM_POS_X:   cfg_q.pos_x    <= cfg_data[31:0];
				sfof_pkg::REG_CAM_POS_Y:   cfg_q.pos_y    <= cfg_data[31:0];
				sfof_pkg::REG_CAM_POS_Z:   cfg_q.pos_z    <= cfg_data[31:0];
				sfof_pkg::REG_CAM_ROT:     cfg_q.rot      <= cfg_data;
				sfof_pkg::REG_NEAR:        cfg_q.near     <= cfg_data[30:0];
				sfof_pkg::REG_TAN_HALF:    cfg_q.tan_half <= cfg_data[30:0];
				sfof_pkg::REG_VIEW_ASPECT: cfg_q.aspect   <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Stall control: each side only looks at its own queue
	assign en_f = !mid_stat.full;
	assign en_b = !out_stat.full;
	assign full = !en_f;

	sfof_front #(
		.FRAC_BITS      (FRAC_BITS),
		.QUAT_FRAC_BITS (QUAT_FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_f),
		.in_valid  (push && en_f),
		.item      (item),
		.cfg       (cfg_q),
		.out_valid (f_valid),
		.mid       (f_mid)
	);

	sfof_fifo #(
		.W     ($bits(sfof_pkg::mid_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_valid && en_f),
		.pop    (en_b && !mid_stat.empty),
		.din    (f_mid),
		.dout   (mid_dout),
		.stat   (mid_stat)
	);

	assign b_mid = mid_dout;

	sfof_back #(
		.FRAC_BITS      (FRAC_BITS),
		.QUAT_FRAC_BITS (QUAT_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_b),
		.in_valid  (!mid_stat.empty),
		.mid       (b_mid),
		.cfg       (cfg_q),
		.out_valid (b_valid),
		.result    (b_res)
	);

	sfof_fifo #(
		.W     ($bits(sfof_pkg::result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (b_valid && en_b),
		.pop    (pop),
		.din    (b_res),
		.dout   (out_dout),
		.stat   (out_stat)
	);

	assign result = out_dout;
	assign empty  = out_stat.empty;

endmodule

// File: src/sfof_chk.sv
`timescale 1ns / 1ps
`include "shadow_frustum_ortho_fit_top_assert.svh"
module sfof_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              empty,
	input logic              pop,
	input sfof_pkg::result_t result
);
	// A waiting result stays put until it is transferred
	`SFOF_ASSERT_NEXT(a_head_holds, !empty && !pop, !empty && $stable(result), "result changed before transfer")

	// A saturated aspect reads as the largest value
	`SFOF_ASSERT_NOW(a_sat_max, !empty && result.aspect_saturated, result.ortho_aspect == sfof_pkg::U31_MAX, "saturated aspect not at maximum")

	// Zero width over a nonzero z extent gives zero aspect
	`SFOF_ASSERT_NOW(a_zero_width, !empty && result.view_width == '0 && !result.aspect_saturated, result.ortho_aspect == '0, "zero width with nonzero aspect")

endmodule

bind shadow_frustum_ortho_fit_top sfof_chk u_sfof_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

// File: test/shadow_frustum_ortho_fit_checker.sv
`timescale 1ns / 1ps
module shadow_frustum_ortho_fit_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic                  full,
	input  sfof_pkg::item_t       item,
	input  logic                  empty,
	input  logic                  pop,
	input  sfof_pkg::result_t     result,
	input  logic                  cfg_we,
	input  logic [sfof_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfof_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending_fits
);
	typedef longint mat9_t [9];

	// Camera registers as last written
	longint    cam_x, cam_y, cam_z;
	logic [63:0] cam_q;
	longint    near_d, tan_h, vp_aspect;

	sfof_pkg::result_t fit_queue[$];

	function automatic longint round_shift(longint v, int s);
		longint t;
		t = v + (64'sd1 <<< (s - 1));
		return t >>> s;
	endfunction

	function automatic longint clamp_s32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint clamp_u31(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < 0)
			return 0;
		return v;
	endfunction

	// Rotation matrix of a Q1.14 quaternion, entry [row*3+col]
	function automatic mat9_t quat_matrix(longint w, longint x, longint y, longint z);
		mat9_t m;
		longint one;
		one = 64'sd1 <<< 28;
		m[0] = clamp_s32(round_shift(one - 2 * (y * y + z * z), 14));
		m[3] = clamp_s32(round_shift(2 * (x * y + w * z), 14));
		m[6] = clamp_s32(round_shift(2 * (x * z - w * y), 14));
		m[1] = clamp_s32(round_shift(2 * (x * y - w * z), 14));
		m[4] = clamp_s32(round_shift(one - 2 * (x * x + z * z), 14));
		m[7] = clamp_s32(round_shift(2 * (y * z + w * x), 14));
		m[2] = clamp_s32(round_shift(2 * (x * z + w * y), 14));
		m[5] = clamp_s32(round_shift(2 * (y * z - w * x), 14));
		m[8] = clamp_s32(round_shift(one - 2 * (x * x + y * y), 14));
		return m;
	endfunction

	function automatic longint mul_q(longint m, longint v);
		return round_shift(m * v, 14);
	endfunction

	function automatic longint scale_len(longint a, longint b);
		logic [63:0] p;
		p = (64'(a) * 64'(b) + 64'd32768) >> 16;
		return (p > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(p);
	endfunction

	function automatic sfof_pkg::result_t fit_ortho(sfof_pkg::item_t it);
		mat9_t cm, lm;
		longint pos[3], slc[2], hh[2], hw[2], mn[3], mx[3], lp[3], wp[3], p[3];
		longint v, back, xext, yext, zext, su, sr;
		logic [63:0] q;
		sfof_pkg::result_t r;
		int s;
		cm = quat_matrix(longint'($signed(cam_q[15:0])), longint'($signed(cam_q[31:16])),
			longint'($signed(cam_q[47:32])), longint'($signed(cam_q[63:48])));
		lm = quat_matrix(longint'(it.light_qw), longint'(it.light_qx),
			longint'(it.light_qy), longint'(it.light_qz));
		back = longint'(it.back_extension);
		pos[0] = cam_x; pos[1] = cam_y; pos[2] = cam_z;
		slc[0] = near_d;
		slc[1] = longint'({33'd0, it.frustum_range});
		hh[0] = scale_len(tan_h, near_d);
		hh[1] = scale_len(tan_h, slc[1]);
		hw[0] = scale_len(hh[0], vp_aspect);
		hw[1] = scale_len(hh[1], vp_aspect);
		// Eight corners, near slice first
		for (int c = 0; c < 8; c++) begin
			s = c >> 2;
			su = ((c & 3) < 2) ? 1 : -1;
			sr = ((c & 1) != 0) ? 1 : -1;
			for (int i = 0; i < 3; i++) begin
				v = pos[i] + mul_q(cm[i*3+1], slc[s]);
				v += su * mul_q(cm[i*3+2], hh[s]);
				v += sr * mul_q(cm[i*3], hw[s]);
				p[i] = clamp_s32(v);
			end
			// Into light space with the transposed matrix
			for (int k = 0; k < 3; k++) begin
				v = 0;
				for (int j = 0; j < 3; j++)
					v += mul_q(lm[j*3+k], p[j]);
				v = clamp_s32(v);
				if (c == 0 || v < mn[k])
					mn[k] = v;
				if (c == 0 || v > mx[k])
					mx[k] = v;
			end
		end
		xext = mx[0] - mn[0];
		yext = mx[1] - mn[1];
		zext = mx[2] - mn[2];
		lp[0] = clamp_s32(round_shift(mn[0] + mx[0], 1));
		lp[1] = clamp_s32(mn[1] - back);
		lp[2] = clamp_s32(round_shift(mn[2] + mx[2], 1));
		for (int i = 0; i < 3; i++) begin
			v = 0;
			for (int k = 0; k < 3; k++)
				v += mul_q(lm[i*3+k], lp[k]);
			wp[i] = clamp_s32(v);
		end
		r.ortho_pos_x = wp[0][31:0];
		r.ortho_pos_y = wp[1][31:0];
		r.ortho_pos_z = wp[2][31:0];
		v = clamp_s32(back + yext);
		r.depth_range = v[31:0];
		v = clamp_u31(xext);
		r.view_width = v[30:0];
		if (zext <= 0) begin
			r.ortho_aspect = sfof_pkg::U31_MAX;
			r.aspect_saturated = 1'b1;
		end else begin
			q = (64'(xext) << 16) / 64'(zext);
			if (q > 64'h7FFF_FFFF) begin
				r.ortho_aspect = sfof_pkg::U31_MAX;
				r.aspect_saturated = 1'b1;
			end else begin
				r.ortho_aspect = q[30:0];
				r.aspect_saturated = 1'b0;
			end
		end
		return r;
	endfunction

	// Watch configuration, input and result transfers
	always @(posedge clk or negedge arst_n) begin
		sfof_pkg::result_t exp_r;
		if (!arst_n) begin
			cam_x = 0; cam_y = 0; cam_z = 0;
			cam_q = sfof_pkg::ROT_RST;
			near_d = sfof_pkg::NEAR_RST;
			tan_h = sfof_pkg::TAN_RST;
			vp_aspect = sfof_pkg::ASPECT_RST;
			fit_queue.delete();
			fail_count = 0;
			pending_fits = 0;
		end else begin
			if (pop && !empty) begin
				if (fit_queue.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result %h", $time, result);
				end else begin
					exp_r = fit_queue.pop_front();
					if (result.ortho_pos_x !== exp_r.ortho_pos_x)
						$display("%0t: ortho_pos_x exp %0d got %0d", $time,
							exp_r.ortho_pos_x, result.ortho_pos_x);
					if (result.ortho_pos_y !== exp_r.ortho_pos_y)
						$display("%0t: ortho_pos_y exp %0d got %0d", $time,
							exp_r.ortho_pos_y, result.ortho_pos_y);
					if (result.ortho_pos_z !== exp_r.ortho_pos_z)
						$display("%0t: ortho_pos_z exp %0d got %0d", $time,
							exp_r.ortho_pos_z, result.ortho_pos_z);
					if (result.depth_range !== exp_r.depth_range)
						$display("%0t: depth_range exp %0d got %0d", $time,
							exp_r.depth_range, result.depth_range);
					if (result.view_width !== exp_r.view_width)
						$display("%0t: view_width exp %0d got %0d", $time,
							exp_r.view_width, result.view_width);
					if (result.ortho_aspect !== exp_r.ortho_aspect)
						$display("%0t: ortho_aspect exp %0d got %0d", $time,
							exp_r.ortho_aspect, result.ortho_aspect);
					if (result.aspect_saturated !== exp_r.aspect_saturated)
						$display("%0t: aspect_saturated exp %0d got %0d", $time,
							exp_r.aspect_saturated, result.aspect_saturated);
					if (result !== exp_r)
						fail_count++;
				end
			end
			if (push && !full)
				fit_queue.push_back(fit_ortho(item));
			if (cfg_we) begin
				case (cfg_index)
					sfof_pkg::REG_CAM_POS_X:
						cam_x = longint'($signed(cfg_data[31:0]));
					sfof_pkg::REG_CAM_POS_Y:
						cam_y = longint'($signed(cfg_data[31:0]));
					sfof_pkg::REG_CAM_POS_Z:
						cam_z = longint'($signed(cfg_data[31:0]));
					sfof_pkg::REG_CAM_ROT:
						cam_q = cfg_data;
					sfof_pkg::REG_NEAR:
						near_d = longint'({33'd0, cfg_data[30:0]});
					sfof_pkg::REG_TAN_HALF:
						tan_h = longint'({33'd0, cfg_data[30:0]});
					sfof_pkg::REG_VIEW_ASPECT:
						vp_aspect = longint'({33'd0, cfg_data[30:0]});
					default: ;
				endcase
			end
			pending_fits = fit_queue.size();
		end
	end
endmodule

// File: test/tb_shadow_frustum_ortho_fit_top.sv
`timescale 1ns / 1ps
module tb_shadow_frustum_ortho_fit_top;
	// Index outside the register list, written to check it is ignored
	localparam logic [sfof_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	sfof_pkg::item_t item = '0;
	sfof_pkg::result_t result;
	logic cfg_we = 1'b0;
	logic [sfof_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [sfof_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	int fail_count, pending_fits;

	// Idle percentages of each side, and a long receiver hold-off
	int send_idle = 0;
	int recv_idle = 0;
	int phase = -1;
	bit recv_hold = 1'b0;

	shadow_frustum_ortho_fit_top i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	shadow_frustum_ortho_fit_checker i_checker (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_fits(pending_fits)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: random pop at each falling edge
	always @(negedge clk)
		pop <= !recv_hold && ($urandom_range(99) >= recv_idle);

	function automatic logic [15:0] rand_quat_half();
		case ($urandom_range(9))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'h8000;
			3: return 16'($urandom);
			default: return 16'($signed($urandom_range(32768)) - 16384);
		endcase
	endfunction

	// Mostly modest lengths, sometimes full-width patterns
	function automatic logic [31:0] rand_len(int big);
		if ($urandom_range(99) < big)
			return $urandom;
		return $urandom_range(32'h0040_0000);
	endfunction

	function automatic sfof_pkg::item_t rand_light();
		sfof_pkg::item_t it;
		int pick;
		pick = $urandom_range(3);
		it.light_qw = rand_quat_half();
		it.light_qx = rand_quat_half();
		it.light_qy = rand_quat_half();
		it.light_qz = rand_quat_half();
		// A few exact axis rotations
		if (pick == 0) begin
			it = '0;
			case ($urandom_range(3))
				0: it.light_qw = 16'sd16384;
				1: it.light_qx = 16'sd16384;
				2: it.light_qy = 16'sd16384;
				default: it.light_qz = -16'sd16384;
			endcase
		end
		it.frustum_range = 31'(rand_len(15));
		it.back_extension = $signed(rand_len(15)) - $signed(32'h0020_0000);
		return it;
	endfunction

	// Offer one item and wait for its transfer; push stays high for a following item
	task automatic send_light(sfof_pkg::item_t it);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (pending_fits != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(logic [sfof_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_camera();
		logic [63:0] rot;
		rot = {rand_quat_half(), rand_quat_half(), rand_quat_half(), rand_quat_half()};
		write_reg(sfof_pkg::REG_CAM_POS_X, {$urandom, $urandom});
		write_reg(sfof_pkg::REG_CAM_POS_Y, 64'($signed(rand_len(20))));
		write_reg(sfof_pkg::REG_CAM_POS_Z, {$urandom, rand_len(50)});
		write_reg(sfof_pkg::REG_CAM_ROT, rot);
		write_reg(sfof_pkg::REG_NEAR, {$urandom, rand_len(10)});
		write_reg(sfof_pkg::REG_TAN_HALF, 64'($urandom_range(32'h0003_0000)));
		write_reg(sfof_pkg::REG_VIEW_ASPECT, 64'($urandom_range(32'h0004_0000)));
		write_reg(REG_UNUSED, {$urandom, $urandom});
	endtask

	initial begin
		sfof_pkg::item_t it;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: extremes, axis rotations, flat slices
		it = '0;
		it.light_qw = 16'sd16384;
		send_light(it);
		it.frustum_range = 31'h7FFF_FFFF;
		it.back_extension = 32'sh7FFF_FFFF;
		send_light(it);
		it.back_extension = 32'sh8000_0000;
		it.light_qw = 16'h8000;
		it.light_qx = 16'h8000;
		it.light_qy = 16'h7FFF;
		it.light_qz = 16'h7FFF;
		send_light(it);
		it = '0;
		send_light(it);
		it.light_qx = 16'sd16384;
		it.frustum_range = 31'd655360;
		send_light(it);
		it.light_qx = 0;
		it.light_qz = -16'sd16384;
		send_light(it);
		it.light_qz = 0;
		it.light_qy = 16'sd11585;
		it.light_qw = 16'sd11585;
		send_light(it);
		it = '1;
		send_light(it);
		drain();
		// Zero-sized slices: near corners on the camera point, far corners on its view axis
		write_reg(sfof_pkg::REG_NEAR, 64'd0);
		write_reg(sfof_pkg::REG_TAN_HALF, 64'd0);
		write_reg(sfof_pkg::REG_VIEW_ASPECT, 64'd0);
		it = '0;
		it.light_qw = 16'sd16384;
		send_light(it);
		it.frustum_range = 31'd65536;
		send_light(it);
		drain();
		write_reg(sfof_pkg::REG_CAM_POS_X, 64'h7FFF_FFFF);
		write_reg(sfof_pkg::REG_CAM_POS_Y, 64'h8000_0000);
		write_reg(sfof_pkg::REG_CAM_POS_Z, 64'hFFFF_FFFF);
		write_reg(sfof_pkg::REG_CAM_ROT, 64'h8000_7FFF_C000_4000);
		write_reg(sfof_pkg::REG_NEAR, 64'h7FFF_FFFF);
		write_reg(sfof_pkg::REG_TAN_HALF, 64'h7FFF_FFFF);
		write_reg(sfof_pkg::REG_VIEW_ASPECT, 64'h7FFF_FFFF);
		it = '0;
		it.light_qw = 16'sd16384;
		send_light(it);
		it.frustum_range = 31'h7FFF_FFFF;
		it.light_qy = 16'sd16384;
		send_light(it);
		drain();

		// Random phases with different idling and camera settings
		for (int ph = 0; ph < 9; ph++) begin
			phase = ph;
			send_idle = (ph < 3) ? 13 : (ph < 6) ? 47 : 0;
			recv_idle = (ph < 3) ? 47 : (ph < 6) ? 13 : 0;
			random_camera();
			if (ph == 8) begin
				// Reset values restored at the end
				write_reg(sfof_pkg::REG_CAM_POS_X, 64'd0);
				write_reg(sfof_pkg::REG_CAM_POS_Y, 64'd0);
				write_reg(sfof_pkg::REG_CAM_POS_Z, 64'd0);
				write_reg(sfof_pkg::REG_CAM_ROT, sfof_pkg::ROT_RST);
				write_reg(sfof_pkg::REG_NEAR, 64'(sfof_pkg::NEAR_RST));
				write_reg(sfof_pkg::REG_TAN_HALF, 64'(sfof_pkg::TAN_RST));
				write_reg(sfof_pkg::REG_VIEW_ASPECT, 64'(sfof_pkg::ASPECT_RST));
			end
			for (int n = 0; n < 148; n++) begin
				send_light(rand_light());
				if (ph == 6 && n == 70)
					drain();
			end
			drain();
		end
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Long receiver hold-off in phase 7 while the sender keeps going
	initial begin
		wait (phase == 7);
		repeat (40) @(negedge clk);
		recv_hold = 1'b1;
		repeat (200) @(negedge clk);
		recv_hold = 1'b0;
	end

	initial begin
		#5ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
